### sv/mvps_pkg.sv
package mvps_pkg;

   // Defaults for the top-level parameters
   localparam int FRAC_BITS_DEF   = 16;
   localparam int ACCUM_WIDTH_DEF = 48;

   // Shared multiplier: 33 x 33 signed (holds 32-bit signed and unsigned operands)
   localparam int OP_W   = 33;
   localparam int PROD_W = 2 * OP_W;
   // Shared adder: wide enough for a full product and a 64-bit accumulator
   localparam int ADD_W  = PROD_W + 1;
   // Integral product assembled from two 32-bit halves of the error sum
   localparam int IW_W   = PROD_W + 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I_SCALED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D_SCALED  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_SCALE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_TICKS = 3'd5;

   localparam logic [14:0] DRIVE_LIMIT_RST = 15'h7fff;

   typedef struct packed {
      logic [31:0] gain_p;
      logic [31:0] gain_i_scaled;
      logic [31:0] gain_d_scaled;
      logic [31:0] vel_scale;
      logic [14:0] drive_limit;
      logic [15:0] response_ticks;
   } cfg_type;

endpackage

### sv/motor_velocity_pid_step_top.sv
// Control update: from input transfer to result valid, one shared
// 33x33 multiplier is stepped through six products by the sequencer.
// Clear, waiting and hold items finish in the cycle they are taken.
// Other items are taken one per cycle while idle; none is taken while an update
// runs, and a result not yet taken holds the next update in its rounding step.
// Synchronous active-high reset zeroes state and config; drive_limit -> 32767.
module motor_velocity_pid_step_top #(
   parameter int FRAC_BITS   = mvps_pkg::FRAC_BITS_DEF,
   parameter int ACCUM_WIDTH = mvps_pkg::ACCUM_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [31:0]                   req_measured_vel,
   input  logic signed [31:0]                   req_reference,
   input  logic                                 req_hold,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [15:0]                   rsp_drive,
   output logic                                 rsp_clamped,
   input  logic                                 csr_wr_en,
   input  logic [mvps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mvps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   mvps_pkg::cfg_type cfg_ff, cfg_in;

   logic signed [mvps_pkg::OP_W-1:0]   mul_a, mul_b;
   logic signed [mvps_pkg::PROD_W-1:0] mul_prod;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            mvps_pkg::CSR_GAIN_P:         cfg_in.gain_p         = csr_wdata;
            mvps_pkg::CSR_GAIN_I_SCALED:  cfg_in.gain_i_scaled  = csr_wdata;
            mvps_pkg::CSR_GAIN_D_SCALED:  cfg_in.gain_d_scaled  = csr_wdata;
            mvps_pkg::CSR_VEL_SCALE:      cfg_in.vel_scale      = csr_wdata;
            mvps_pkg::CSR_DRIVE_LIMIT:    cfg_in.drive_limit    = csr_wdata[14:0];
            mvps_pkg::CSR_RESPONSE_TICKS: cfg_in.response_ticks = csr_wdata[15:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i_scaled  <= '0;
         cfg_ff.gain_d_scaled  <= '0;
         cfg_ff.vel_scale      <= '0;
         cfg_ff.drive_limit    <= mvps_pkg::DRIVE_LIMIT_RST;
         cfg_ff.response_ticks <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mvps_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   mvps_core #(
      .FRAC_BITS   (FRAC_BITS),
      .ACCUM_WIDTH (ACCUM_WIDTH)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_measured_vel (req_measured_vel),
      .req_reference    (req_reference),
      .req_hold         (req_hold),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive        (rsp_drive),
      .rsp_clamped      (rsp_clamped),
      .mul_a            (mul_a),
      .mul_b            (mul_b),
      .mul_prod         (mul_prod)
   );

endmodule

### sv/mvps_mul.sv
module mvps_mul (
   input  logic                                 clock,
   input  logic signed [mvps_pkg::OP_W-1:0]     op_a,
   input  logic signed [mvps_pkg::OP_W-1:0]     op_b,
   output logic signed [mvps_pkg::PROD_W-1:0]   prod
);

   logic signed [mvps_pkg::PROD_W-1:0] prod_ff;
   logic signed [mvps_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mvps_pkg::PROD_W'(op_a) * mvps_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### sv/mvps_core.sv
module mvps_core #(
   parameter int FRAC_BITS   = mvps_pkg::FRAC_BITS_DEF,
   parameter int ACCUM_WIDTH = mvps_pkg::ACCUM_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mvps_pkg::cfg_type                    cfg,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [31:0]                   req_measured_vel,
   input  logic signed [31:0]                   req_reference,
   input  logic                                 req_hold,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [15:0]                   rsp_drive,
   output logic                                 rsp_clamped,
   output logic signed [mvps_pkg::OP_W-1:0]     mul_a,
   output logic signed [mvps_pkg::OP_W-1:0]     mul_b,
   input  logic signed [mvps_pkg::PROD_W-1:0]   mul_prod
);

   localparam int ADD_W     = mvps_pkg::ADD_W;
   localparam int OP_W      = mvps_pkg::OP_W;
   localparam int PROD_W    = mvps_pkg::PROD_W;
   localparam int IW_W      = mvps_pkg::IW_W;
   localparam int VEL_SHIFT = 32 - FRAC_BITS;

   localparam logic signed [ADD_W-1:0] ROUND_UP = ADD_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [ADD_W-1:0] ROUND_DN = ROUND_UP - ADD_W'(1);
   localparam logic signed [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
   localparam logic signed [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
   localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
   localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_ERR   = 11'b000_0000_0010,
      ST_MTICK = 11'b000_0000_0100,
      ST_ACCUM = 11'b000_0000_1000,
      ST_PTERM = 11'b000_0001_0000,
      ST_ILO   = 11'b000_0010_0000,
      ST_IHI   = 11'b000_0100_0000,
      ST_IADD  = 11'b000_1000_0000,
      ST_DTERM = 11'b001_0000_0000,
      ST_CLAMP = 11'b010_0000_0000,
      ST_ROUND = 11'b100_0000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [15:0]                    tick_ff, tick_in;
   logic signed [31:0]             last_err_ff, last_err_in;
   logic signed [ACCUM_WIDTH-1:0]  accum_ff, accum_in;
   logic signed [ACCUM_WIDTH-1:0]  action_ff, action_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic signed [31:0]             ref_ff, ref_in;
   logic signed [31:0]             err_ff, err_in;
   logic signed [32:0]             diff_ff, diff_in;
   logic signed [63:0]             sum_ff, sum_in;
   logic signed [PROD_W-1:0]       ilo_ff, ilo_in;
   logic signed [IW_W-1:0]         iwide_ff, iwide_in;
   logic                           clamp_ff, clamp_in;
   logic signed [15:0]             drive_ff, drive_in;
   logic                           clamped_ff, clamped_in;

   logic                           accept;
   logic                           slot_free;
   logic signed [ADD_W-1:0]        add_a, add_b, add_res;
   logic                           add_sub;
   logic signed [PROD_W-1:0]       vel_shf, prod_shf;
   logic signed [IW_W-1:0]         i_shf;
   logic signed [63:0]             i_sat;
   logic signed [63:0]             acc64;
   logic signed [31:0]             sat32;
   logic signed [63:0]             sat64;
   logic signed [ACCUM_WIDTH-1:0]  satacc;
   logic signed [63:0]             lim, neg_lim, sum_c;
   logic                           clamp_hi, clamp_lo;
   logic signed [ACCUM_WIDTH-1:0]  act_c;
   logic [ADD_W-32:0]              hi32;
   logic [ADD_W-64:0]              hi64;
   logic [ADD_W-ACCUM_WIDTH:0]     hiacc;
   logic [IW_W-64:0]               hii;
   logic [64-ACCUM_WIDTH:0]        hiclamp;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign acc64    = 64'(accum_ff);
   assign vel_shf  = mul_prod >>> VEL_SHIFT;
   assign prod_shf = mul_prod >>> FRAC_BITS;
   assign i_shf    = iwide_ff >>> FRAC_BITS;

   // Saturation checks: the upper bits must all match the sign
   assign hii   = i_shf[IW_W-1:63];
   assign i_sat = ((&hii) || !(|hii)) ? i_shf[63:0] : (i_shf[IW_W-1] ? S64_MIN : S64_MAX);

   assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);

   assign hi32   = add_res[ADD_W-1:31];
   assign sat32  = ((&hi32) || !(|hi32)) ? add_res[31:0]
                                         : (add_res[ADD_W-1] ? S32_MIN : S32_MAX);
   assign hi64   = add_res[ADD_W-1:63];
   assign sat64  = ((&hi64) || !(|hi64)) ? add_res[63:0]
                                         : (add_res[ADD_W-1] ? S64_MIN : S64_MAX);
   assign hiacc  = add_res[ADD_W-1:ACCUM_WIDTH-1];
   assign satacc = ((&hiacc) || !(|hiacc)) ? add_res[ACCUM_WIDTH-1:0]
                                           : (add_res[ADD_W-1] ? ACC_MIN : ACC_MAX);

   // Output limit against +/- drive_limit in fixed point
   assign lim      = signed'({49'd0, cfg.drive_limit} << FRAC_BITS);
   assign neg_lim  = -lim;
   assign clamp_hi = sum_ff > lim;
   assign clamp_lo = sum_ff < neg_lim;
   assign sum_c    = clamp_hi ? lim : (clamp_lo ? neg_lim : sum_ff);
   assign hiclamp  = sum_c[63:ACCUM_WIDTH-1];
   assign act_c    = ((&hiclamp) || !(|hiclamp)) ? sum_c[ACCUM_WIDTH-1:0]
                                                 : (sum_c[63] ? ACC_MIN : ACC_MAX);

   // Multiplier operands; the product comes back through a register in mvps_mul
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            mul_a = OP_W'(req_measured_vel);
            mul_b = signed'({1'b0, cfg.vel_scale});
         end
         ST_MTICK: begin
            mul_a = OP_W'(err_ff);
            mul_b = signed'({17'd0, tick_ff});
         end
         ST_ACCUM: begin
            mul_a = OP_W'(signed'(cfg.gain_p));
            mul_b = OP_W'(err_ff);
         end
         ST_PTERM: begin
            mul_a = OP_W'(signed'(cfg.gain_i_scaled));
            mul_b = signed'({1'b0, acc64[31:0]});
         end
         ST_ILO: begin
            // upper half carries the sign of the error sum
            mul_a = OP_W'(signed'(cfg.gain_i_scaled));
            mul_b = OP_W'(signed'(acc64[63:32]));
         end
         default: begin
            mul_a = OP_W'(signed'(cfg.gain_d_scaled));
            mul_b = diff_ff;
         end
      endcase
   end

   // Shared adder operands
   always_comb begin
      add_sub = 1'b0;
      case (state_ff)
         ST_ERR: begin
            add_a   = ADD_W'(ref_ff);
            add_b   = ADD_W'(vel_shf);
            add_sub = 1'b1;
         end
         ST_MTICK: begin
            add_a   = ADD_W'(err_ff);
            add_b   = ADD_W'(last_err_ff);
            add_sub = 1'b1;
         end
         ST_ACCUM: begin
            add_a = ADD_W'(accum_ff);
            add_b = ADD_W'(mul_prod);
         end
         ST_PTERM: begin
            add_a = ADD_W'(action_ff);
            add_b = ADD_W'(prod_shf);
         end
         ST_IADD: begin
            add_a = ADD_W'(sum_ff);
            add_b = ADD_W'(i_sat);
         end
         ST_DTERM: begin
            add_a = ADD_W'(sum_ff);
            add_b = ADD_W'(prod_shf);
         end
         ST_ROUND: begin
            // half away from zero: negative values add one less
            add_a = ADD_W'(action_ff);
            add_b = action_ff[ACCUM_WIDTH-1] ? ROUND_DN : ROUND_UP;
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      last_err_in  = last_err_ff;
      accum_in     = accum_ff;
      action_in    = action_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ref_in       = ref_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      sum_in       = sum_ff;
      ilo_in       = ilo_ff;
      iwide_in     = iwide_ff;
      clamp_in     = clamp_ff;
      drive_in     = drive_ff;
      clamped_in   = clamped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ref_in = req_reference;
               if (req_cmd) begin
                  tick_in     = '0;
                  last_err_in = '0;
                  accum_in    = '0;
                  action_in   = '0;
               end else if (cfg.response_ticks > tick_ff) begin
                  tick_in = tick_ff + 16'd1;
               end else if (!req_hold) begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            err_in   = sat32;
            state_in = ST_MTICK;
         end
         ST_MTICK: begin
            diff_in     = add_res[32:0];
            last_err_in = err_ff;
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            accum_in = satacc;
            state_in = ST_PTERM;
         end
         ST_PTERM: begin
            sum_in   = sat64;
            state_in = ST_ILO;
         end
         ST_ILO: begin
            ilo_in   = mul_prod;
            state_in = ST_IHI;
         end
         ST_IHI: begin
            iwide_in = (IW_W'(mul_prod) <<< 32) + IW_W'(ilo_ff);
            state_in = ST_IADD;
         end
         ST_IADD: begin
            sum_in   = sat64;
            state_in = ST_DTERM;
         end
         ST_DTERM: begin
            sum_in   = sat64;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            action_in = act_c;
            clamp_in  = clamp_hi || clamp_lo;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            // hold until the output register can take the transfer
            if (slot_free) begin
               drive_in     = add_res[FRAC_BITS+15:FRAC_BITS];
               clamped_in   = clamp_ff;
               rsp_valid_in = 1'b1;
               tick_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         last_err_ff  <= '0;
         accum_ff     <= '0;
         action_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         last_err_ff  <= last_err_in;
         accum_ff     <= accum_in;
         action_ff    <= action_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_ff     <= ref_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      sum_ff     <= sum_in;
      ilo_ff     <= ilo_in;
      iwide_ff   <= iwide_in;
      clamp_ff   <= clamp_in;
      drive_ff   <= drive_in;
      clamped_ff <= clamped_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = drive_ff;
   assign rsp_clamped = clamped_ff;

endmodule

### test/pid_drive_checker.sv
`timescale 1ns / 1ps

module pid_drive_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [31:0]                   req_measured_vel,
   input  logic signed [31:0]                   req_reference,
   input  logic                                 req_hold,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [15:0]                   rsp_drive,
   input  logic                                 rsp_clamped,
   input  logic                                 csr_wr_en,
   input  logic [mvps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mvps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                   mismatch_count,
   output int                                   drive_pending,
   output int                                   drive_count,
   output int                                   clamp_count
);

   localparam int QF = mvps_pkg::FRAC_BITS_DEF;
   localparam int AW = mvps_pkg::ACCUM_WIDTH_DEF;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               clamped;
   } drive_result_type;

   drive_result_type     drive_queue[$];
   mvps_pkg::cfg_type    ctrl_cfg;
   logic [15:0]          ticks;
   logic signed [63:0]   last_err;
   logic signed [63:0]   err_sum;
   logic signed [63:0]   act_q;

   initial begin
      mismatch_count = 0;
      drive_pending  = 0;
      drive_count    = 0;
      clamp_count    = 0;
   end

   function automatic logic signed [63:0] clip(input logic signed [127:0] v, input int w);
      logic signed [127:0] hi_bound;
      logic signed [127:0] lo_bound;
      hi_bound = 128'sd1;
      hi_bound = (hi_bound <<< (w - 1)) - 128'sd1;
      lo_bound = -hi_bound - 128'sd1;
      if (v > hi_bound) begin
         return hi_bound[63:0];
      end else if (v < lo_bound) begin
         return lo_bound[63:0];
      end
      return v[63:0];
   endfunction

   function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [127:0] wide;
      wide = 128'(a);
      wide = wide + 128'(b);
      return clip(wide, 64);
   endfunction

   // exact product, shifted with floor, saturated to 64 bits
   function automatic logic signed [63:0] mul_floor(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input int sh);
      logic signed [127:0] wide;
      wide = 128'(a) * 128'(b);
      wide = wide >>> sh;
      return clip(wide, 64);
   endfunction

   task automatic advance_controller(input logic cmd,
                                     input logic signed [31:0] vel,
                                     input logic signed [31:0] setpoint,
                                     input logic hold_bit,
                                     output bit emitted,
                                     output drive_result_type res);
      logic signed [127:0] wide;
      logic signed [63:0]  vel64, scale64, scaled, err64, tick64, diff64;
      logic signed [63:0]  g64, p_term, i_term, d_term, total, lim64;
      logic signed [63:0]  magnitude, rounded, drive64;
      logic                hit_limit;
      emitted = 1'b0;
      res     = '0;
      if (cmd) begin
         ticks    = '0;
         last_err = '0;
         err_sum  = '0;
         act_q    = '0;
      end else if (ctrl_cfg.response_ticks > ticks) begin
         ticks = ticks + 16'd1;
      end else if (!hold_bit) begin
         vel64   = 64'(vel);
         scale64 = {32'd0, ctrl_cfg.vel_scale};
         scaled  = mul_floor(vel64, scale64, 32 - QF);
         wide    = 128'(setpoint);
         wide    = wide - 128'(scaled);
         err64   = clip(wide, 32);

         tick64  = {48'd0, ticks};
         wide    = 128'(err_sum);
         wide    = wide + 128'(err64) * 128'(tick64);
         err_sum = clip(wide, AW);
         diff64  = err64 - last_err;
         last_err = err64;

         g64    = 64'($signed(ctrl_cfg.gain_p));
         p_term = mul_floor(g64, err64, QF);
         g64    = 64'($signed(ctrl_cfg.gain_i_scaled));
         i_term = mul_floor(g64, err_sum, QF);
         g64    = 64'($signed(ctrl_cfg.gain_d_scaled));
         d_term = mul_floor(g64, diff64, QF);
         total  = add_sat(add_sat(add_sat(act_q, p_term), i_term), d_term);

         lim64 = 64'(ctrl_cfg.drive_limit);
         lim64 = lim64 <<< QF;
         hit_limit = 1'b0;
         if (total > lim64) begin
            total = lim64;
            hit_limit = 1'b1;
         end else if (total < -lim64) begin
            total = -lim64;
            hit_limit = 1'b1;
         end
         act_q = clip(128'(total), AW);
         ticks = '0;

         // round half away from zero
         magnitude = (act_q < 0) ? -act_q : act_q;
         rounded   = (magnitude + (64'sd1 <<< (QF - 1))) >>> QF;
         drive64   = (act_q < 0) ? -rounded : rounded;
         res.drive   = drive64[15:0];
         res.clamped = hit_limit;
         emitted     = 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      drive_result_type got;
      drive_result_type want;
      drive_result_type fresh;
      bit               emitted;
      if (reset) begin
         ctrl_cfg                = '0;
         ctrl_cfg.drive_limit    = mvps_pkg::DRIVE_LIMIT_RST;
         ticks                   = '0;
         last_err                = '0;
         err_sum                 = '0;
         act_q                   = '0;
         drive_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.drive   = rsp_drive;
            got.clamped = rsp_clamped;
            if (drive_queue.size() == 0) begin
               $error("drive transfer with none expected: drive %0d clamped %0b",
                      got.drive, got.clamped);
               mismatch_count++;
            end else begin
               want = drive_queue.pop_front();
               drive_count++;
               if (want.clamped) clamp_count++;
               if (got.drive !== want.drive) begin
                  $error("drive mismatch: expected %0d, actual %0d", want.drive, got.drive);
                  mismatch_count++;
               end
               if (got.clamped !== want.clamped) begin
                  $error("clamped mismatch: expected %0b, actual %0b",
                         want.clamped, got.clamped);
                  mismatch_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               mvps_pkg::CSR_GAIN_P:         ctrl_cfg.gain_p         = csr_wdata;
               mvps_pkg::CSR_GAIN_I_SCALED:  ctrl_cfg.gain_i_scaled  = csr_wdata;
               mvps_pkg::CSR_GAIN_D_SCALED:  ctrl_cfg.gain_d_scaled  = csr_wdata;
               mvps_pkg::CSR_VEL_SCALE:      ctrl_cfg.vel_scale      = csr_wdata;
               mvps_pkg::CSR_DRIVE_LIMIT:    ctrl_cfg.drive_limit    = csr_wdata[14:0];
               mvps_pkg::CSR_RESPONSE_TICKS: ctrl_cfg.response_ticks = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_controller(req_cmd, req_measured_vel, req_reference, req_hold,
                               emitted, fresh);
            if (emitted) drive_queue.push_back(fresh);
         end
      end
      drive_pending <= drive_queue.size();
   end

endmodule

### test/tb_motor_velocity_pid_step_top.sv
`timescale 1ns / 1ps

module tb_motor_velocity_pid_step_top;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [mvps_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic                                 req_cmd;
   logic signed [31:0]                   req_measured_vel;
   logic signed [31:0]                   req_reference;
   logic                                 req_hold;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic signed [15:0]                   rsp_drive;
   logic                                 rsp_clamped;
   logic                                 csr_wr_en;
   logic [mvps_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [mvps_pkg::CSR_DATA_W-1:0]      csr_wdata;

   int mismatch_count;
   int drive_pending;
   int drive_count;
   int clamp_count;

   int cycle_count    = 0;
   int req_quiet      = 0;
   int rsp_quiet      = 0;
   int items_sent     = 0;
   int clears_sent    = 0;
   int holds_sent     = 0;
   int settings_count = 0;

   motor_velocity_pid_step_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_measured_vel (req_measured_vel),
      .req_reference    (req_reference),
      .req_hold         (req_hold),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive        (rsp_drive),
      .rsp_clamped      (rsp_clamped),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pid_drive_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_measured_vel (req_measured_vel),
      .req_reference    (req_reference),
      .req_hold         (req_hold),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive        (rsp_drive),
      .rsp_clamped      (rsp_clamped),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .drive_pending    (drive_pending),
      .drive_count      (drive_count),
      .clamp_count      (clamp_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d drive results still pending",
                  cycle_count, drive_pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // mostly random gaps, with occasional stretches of back-to-back transfers
   task automatic pick_wait(inout int quiet, output int cycles);
      if (quiet > 0) begin
         quiet--;
         cycles = 0;
      end else if ($urandom_range(0, 9) == 0) begin
         quiet  = $urandom_range(10, 40);
         cycles = 0;
      end else begin
         cycles = $urandom_range(0, 18);
      end
   endtask

   initial begin : rsp_side
      int gap;
      rsp_ready <= 1'b0;
      forever begin
         pick_wait(rsp_quiet, gap);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_tick(input logic cmd, input logic signed [31:0] vel,
                            input logic signed [31:0] setpoint, input logic hold_bit);
      int gap;
      pick_wait(req_quiet, gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_measured_vel <= vel;
      req_reference    <= setpoint;
      req_hold         <= hold_bit;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
      if (cmd) clears_sent++;
      else if (hold_bit) holds_sent++;
   endtask

   // hold off until every drive result is back and the block has settled
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drive_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] gp, input logic [31:0] gi,
                                 input logic [31:0] gd, input logic [31:0] vscale,
                                 input logic [14:0] limit, input logic [15:0] resp);
      logic [31:0] junk;
      junk = $urandom;
      csr_wr_en <= 1'b1;
      csr_index <= mvps_pkg::CSR_GAIN_P;
      csr_wdata <= gp;
      @(posedge clock);
      csr_index <= mvps_pkg::CSR_GAIN_I_SCALED;
      csr_wdata <= gi;
      @(posedge clock);
      csr_index <= mvps_pkg::CSR_GAIN_D_SCALED;
      csr_wdata <= gd;
      @(posedge clock);
      csr_index <= mvps_pkg::CSR_VEL_SCALE;
      csr_wdata <= vscale;
      @(posedge clock);
      // upper bits beyond the register width are don't-care
      csr_index <= mvps_pkg::CSR_DRIVE_LIMIT;
      csr_wdata <= {junk[31:15], limit};
      @(posedge clock);
      csr_index <= mvps_pkg::CSR_RESPONSE_TICKS;
      csr_wdata <= {junk[15:0], resp};
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= ~junk;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   function automatic logic [31:0] pick_gain();
      int v;
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return 32'h0;
         default: begin
            v = $urandom_range(0, 262144);
            return v - 131072;
         end
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0] vscale;
      logic [14:0] limit;
      logic [15:0] resp;
      logic signed [31:0] vel, setpoint;
      int phase, n;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= 1'b0;
      req_measured_vel <= '0;
      req_reference    <= '0;
      req_hold         <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_index        <= mvps_pkg::CSR_GAIN_P;
      csr_wdata        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // register defaults: zero gains give zero drive
      send_tick(1'b0, 32'sd1000, 32'sh0001_0000, 1'b0);
      send_tick(1'b1, 32'sd0, 32'sd0, 1'b0);
      drain_results();

      // unity P, quarter I, half D, 1024 counts per rev, limit 100
      apply_settings(32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0040_0000,
                     15'd100, 16'd0);
      send_tick(1'b0, 32'sd0, 32'sd0, 1'b0);
      send_tick(1'b0, 32'sd1024, 32'sh0002_0000, 1'b0);
      send_tick(1'b0, 32'sd1024, 32'sh0002_0000, 1'b1);
      send_tick(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
      send_tick(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
      send_tick(1'b0, -32'sd1, -32'sd1, 1'b0);
      send_tick(1'b1, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
      drain_results();

      // extreme gains and scale, three-tick wait between updates
      apply_settings(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                     15'h7fff, 16'd3);
      for (n = 0; n < 3; n++) send_tick(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, n[0]);
      send_tick(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
      send_tick(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
      for (n = 0; n < 3; n++) send_tick(1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
      send_tick(1'b0, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
      drain_results();

      // zero limit pins the drive at zero
      apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0040_0000,
                     15'd0, 16'd0);
      send_tick(1'b0, 32'sd500, 32'sh0003_0000, 1'b0);
      send_tick(1'b0, -32'sd700, -32'sh0005_0000, 1'b0);
      drain_results();

      // longest wait: these only count
      apply_settings(32'h0000_8000, 32'h0000_1000, 32'h0000_0000, 32'h0010_0000,
                     15'd2000, 16'hffff);
      send_tick(1'b0, 32'sd10, 32'sd20, 1'b0);
      send_tick(1'b0, 32'sd10, 32'sd20, 1'b1);
      drain_results();

      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 3))
            0: vscale = $urandom;
            1: vscale = 32'h0;
            default: vscale = 32'hffff_ffff / $urandom_range(1, 4096);
         endcase
         case ($urandom_range(0, 3))
            0: limit = 15'd0;
            1: limit = 15'h7fff;
            default: limit = 15'($urandom_range(1, 2000));
         endcase
         resp = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 12))
                                            : 16'($urandom_range(0, 3));
         apply_settings(pick_gain(), pick_gain(), pick_gain(), vscale, limit, resp);
         for (n = 0; n < 225; n++) begin
            if ($urandom_range(0, 149) == 0) drain_results();
            vel = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20000) - 10000;
            setpoint = ($urandom_range(0, 4) == 0) ? $urandom
                                                   : $urandom_range(0, 13107200) - 6553600;
            send_tick($urandom_range(0, 39) == 0, vel, setpoint, $urandom_range(0, 9) == 0);
         end
         drain_results();
      end

      $display("Sent %0d items (%0d clears, %0d held) under %0d register settings.",
               items_sent, clears_sent, holds_sent, settings_count);
      $display("Compared %0d drive results, %0d of them at the action limit.",
               drive_count, clamp_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### motor_velocity_pid_step_top.f
sv/mvps_pkg.sv
sv/mvps_mul.sv
sv/mvps_core.sv
sv/motor_velocity_pid_step_top.sv
test/pid_drive_checker.sv
test/tb_motor_velocity_pid_step_top.sv
